@@ sv/bvms_pkg.sv @@
// shared types and constants of the beaver vector-matrix share unit
`timescale 1ns / 1ps

package bvms_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS    = 1'b0,
    CFG_PARTY_ZERO = 1'b1
  } cfg_idx_e;

  // per-row control carried through the queue
  typedef struct packed {
    logic first;
    logic last;
  } row_flags_t;

  localparam int FLAGS_W = $bits(row_flags_t);

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_FIN
  } back_state_e;

  // multiplier schedule inside ST_MUL
  typedef enum logic [1:0] {
    STEP_DB  = 2'd0,
    STEP_AE  = 2'd1,
    STEP_DE  = 2'd2,
    STEP_END = 2'd3
  } mul_step_e;

endpackage

@@ sv/bvms_if.sv @@
// valid/ready channel interfaces for input rows and output shares
`timescale 1ns / 1ps

interface bvms_in_if #(
  parameter int VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] d_value;
  logic [VALUE_WIDTH-1:0] a_share;
  logic [VALUE_WIDTH-1:0] b_share;
  logic [VALUE_WIDTH-1:0] e_value;
  logic [VALUE_WIDTH-1:0] c_share;
  logic                   last_row;

  modport source (
    output valid, d_value, a_share, b_share, e_value, c_share, last_row,
    input  ready
  );
  modport sink (
    input  valid, d_value, a_share, b_share, e_value, c_share, last_row,
    output ready
  );
endinterface

interface bvms_out_if #(
  parameter int VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] z_share;

  modport source (
    output valid, z_share,
    input  ready
  );
  modport sink (
    input  valid, z_share,
    output ready
  );
endinterface

@@ sv/bvms_front.sv @@
// front end: accepts rows, tags the first row of each column, builds queue entries
`timescale 1ns / 1ps

module bvms_front import bvms_pkg::*; #(
  parameter int VALUE_WIDTH = 31,
  parameter int ENTRY_W     = 5 * VALUE_WIDTH + FLAGS_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bvms_in_if.sink            in_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output logic [ENTRY_W-1:0] q_data_o
);

  logic       col_start_q;
  logic       col_start_d;
  row_flags_t flags;

  // accept whenever the queue has room
  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid & q_ready_i;

  // column tracking: a last row makes the next row a first row
  always_comb begin
    col_start_d = col_start_q;
    if (q_push_o) begin
      col_start_d = in_i.last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_start_q <= 1'b1;
    end else begin
      col_start_q <= col_start_d;
    end
  end

  // queue entry layout: flags, c, e, b, a, d
  assign flags.first = col_start_q;
  assign flags.last  = in_i.last_row;
  assign q_data_o    = {flags, in_i.c_share, in_i.e_value, in_i.b_share,
                        in_i.a_share, in_i.d_value};

endmodule

@@ sv/bvms_queue.sv @@
// short register queue between front and back ends
`timescale 1ns / 1ps

module bvms_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              pop_valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CNT_W'(DEPTH)))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

@@ sv/bvms_back.sv @@
// back end: sums d*b, a*e and, for party zero, d*e with one multiplier, reduces bit-serially
`timescale 1ns / 1ps

module bvms_back import bvms_pkg::*; #(
  parameter int VALUE_WIDTH = 31,
  parameter int ENTRY_W     = 5 * VALUE_WIDTH + FLAGS_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] modulus_i,
  input  logic                   party_zero_i,
  input  logic                   q_valid_i,
  input  logic [ENTRY_W-1:0]     q_data_i,
  output logic                   q_pop_o,
  bvms_out_if.source             out_o
);

  localparam int W     = VALUE_WIDTH;
  localparam int PW    = 2 * W;
  localparam int TW    = 2 * W + 2;
  localparam int CNT_W = $clog2(TW);

  back_state_e     state_q, state_d;
  mul_step_e       step_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]    d_q, a_q, b_q, e_q;
  row_flags_t      flags_q;
  logic [PW-1:0]   prod_q;
  logic [TW-1:0]   acc_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    col_sum_q;
  logic            out_valid_q;
  logic [W-1:0]    out_z_q;

  // queue entry fields
  logic [W-1:0]    q_d, q_a, q_b, q_e, q_c;
  row_flags_t      q_flags;
  logic [W-1:0]    base;

  // arithmetic
  logic [W-1:0]    mul_x, mul_y;
  logic [PW-1:0]   mul_p;
  logic [TW-1:0]   acc_add;
  logic [W:0]      rem_t, rem_m;
  logic [W-1:0]    rem_next;
  logic            mod_small;
  logic [W-1:0]    share;

  // control
  logic            out_free;
  logic            fin_fire;

  assign q_d     = q_data_i[W-1:0];
  assign q_a     = q_data_i[2*W-1:W];
  assign q_b     = q_data_i[3*W-1:2*W];
  assign q_e     = q_data_i[4*W-1:3*W];
  assign q_c     = q_data_i[5*W-1:4*W];
  assign q_flags = q_data_i[ENTRY_W-1:5*W];
  assign base    = q_flags.first ? q_c : col_sum_q;

  // multiplier operand schedule
  always_comb begin
    case (step_q)
      STEP_DB: begin
        mul_x = d_q;
        mul_y = b_q;
      end
      STEP_AE: begin
        mul_x = a_q;
        mul_y = e_q;
      end
      default: begin
        mul_x = d_q;
        mul_y = e_q;
      end
    endcase
  end

  assign mul_p = PW'(mul_x) * PW'(mul_y);

  // product of the previous step joins the sum; d*e only for party zero
  always_comb begin
    case (step_q)
      STEP_DB:  acc_add = '0;
      STEP_END: acc_add = party_zero_i ? TW'(prod_q) : '0;
      default:  acc_add = TW'(prod_q);
    endcase
  end

  // one remainder bit per cycle: r = (2r + bit) mod m
  assign rem_t    = {rem_q, acc_q[TW-1]};
  assign rem_m    = {1'b0, modulus_i};
  assign rem_next = (rem_t >= rem_m) ? W'(rem_t - rem_m) : W'(rem_t);

  assign mod_small = (modulus_i < W'(2));
  assign share     = mod_small ? '0 : rem_q;
  assign out_free  = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (step_q == STEP_END) state_d = ST_RED;
      end
      ST_RED: begin
        if (cnt_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!flags_q.last || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop_o  = 1'b0;
    fin_fire = 1'b0;
    case (state_q)
      ST_IDLE: q_pop_o  = q_valid_i;
      ST_FIN:  fin_fire = !flags_q.last || out_free;
      default: begin
        q_pop_o  = 1'b0;
        fin_fire = 1'b0;
      end
    endcase
  end

  // control state, running column sum and output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      col_sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (fin_fire && flags_q.last) begin
        out_valid_q <= 1'b1;
        col_sum_q   <= '0;
      end else begin
        if (out_o.ready) out_valid_q <= 1'b0;
        if (fin_fire) col_sum_q <= share;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        d_q     <= q_d;
        a_q     <= q_a;
        b_q     <= q_b;
        e_q     <= q_e;
        flags_q <= q_flags;
        acc_q   <= TW'(base);
        rem_q   <= '0;
        step_q  <= STEP_DB;
      end
      ST_MUL: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + acc_add;
        step_q <= mul_step_e'(step_q + 2'd1);
        cnt_q  <= CNT_W'(TW - 1);
      end
      ST_RED: begin
        rem_q <= rem_next;
        acc_q <= {acc_q[TW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      default: begin
        if (fin_fire && flags_q.last) out_z_q <= share;
      end
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.z_share = out_z_q;

`ifndef SYNTHESIS
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED && !mod_small) |-> (rem_q < modulus_i))
    else $error("partial remainder not below modulus");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN && flags_q.last))
    else $error("share emitted outside a last row");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_MUL && step_q == STEP_DB))
    else $error("popped row did not start the multiply schedule");
`endif

endmodule

@@ sv/beaver_vector_matrix_share_unit.sv @@
// top level: config registers, front end, row queue, back end
// a row passes the front end and the queue, then the back end loads it, runs the multiplier
// steps, reduces the sum bit-serially and finishes; the share of a last row is registered
// the back end takes a new row only after it has finished the last one
// the queue takes QUEUE_DEPTH rows ahead of the back end, the output register holds one share
// reset: modulus 64, party_zero 0, next row starts a column, queue empty, no clearing pass
`timescale 1ns / 1ps

module beaver_vector_matrix_share_unit import bvms_pkg::*; #(
  parameter int VALUE_WIDTH = 31,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  bvms_in_if.sink                in_i,
  bvms_out_if.source             out_o
);

  localparam int ENTRY_W = 5 * VALUE_WIDTH + FLAGS_W;

  logic [VALUE_WIDTH-1:0] modulus_q;
  logic                   party_zero_q;
  logic                   q_push;
  logic                   q_ready;
  logic [ENTRY_W-1:0]     q_wdata;
  logic                   q_pop;
  logic                   q_valid;
  logic [ENTRY_W-1:0]     q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= VALUE_WIDTH'(64);
      party_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS:    modulus_q    <= cfg_data_i;
        CFG_PARTY_ZERO: party_zero_q <= cfg_data_i[0];
        default:        party_zero_q <= party_zero_q;
      endcase
    end
  end

  bvms_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  bvms_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_wdata),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_data_o   (q_rdata),
    .pop_valid_o  (q_valid)
  );

  bvms_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .modulus_i    (modulus_q),
    .party_zero_i (party_zero_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_o        (out_o)
  );

endmodule

@@ test/beaver_vector_matrix_share_unit_test.sv @@
// self-checking bench for the beaver vector-matrix share unit: directed rows, then random columns
`timescale 1ns / 1ps

module beaver_vector_matrix_share_unit_test;
  import bvms_pkg::*;

  localparam int VW = 31;
  localparam int QDEPTH = 2;
  // one row through the bit-serial back end
  localparam int LATENCY = 2 * VW + 8;
  // enough for the queue and the back end to run dry of rows that give no share
  localparam int SETTLE_CYCLES = (QDEPTH + 2) * LATENCY;
  localparam int HOLD_CYCLES = 1500;
  localparam int PRESSURE_ROWS = 12;
  localparam int RANDOM_ROWS = 1600;
  localparam int ROWS_PER_PHASE = 80;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [VW-1:0] ONES = '1;

  typedef enum logic {
    ACT_ROW,
    ACT_CFG
  } plan_act_e;

  typedef struct {
    logic [VW-1:0] d;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] e;
    logic [VW-1:0] c;
    logic          last;
  } row_t;

  typedef struct {
    plan_act_e     act;
    cfg_idx_e      idx;
    logic [VW-1:0] val;
    row_t          row;
    bit            typed;
    logic [VW-1:0] z;
  } plan_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VW-1:0] cfg_data;

  bvms_in_if  #(.VALUE_WIDTH(VW)) row_ch ();
  bvms_out_if #(.VALUE_WIDTH(VW)) share_ch ();

  beaver_vector_matrix_share_unit #(
    .VALUE_WIDTH(VW),
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (row_ch),
    .out_o     (share_ch)
  );

  always #10 clk = ~clk;

  // predictor state: registers and the running column share
  logic [VW-1:0] modulus_reg;
  bit            party_zero_reg;
  logic [VW-1:0] run_sum;
  bit            col_first;

  logic [VW-1:0] pending_shares[$];
  plan_t         directed_plan[$];

  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;
  bit     hold_request = 1'b0;
  int     rows_sent = 0;
  int     mismatch_count = 0;
  longint cycle_count = 0;

  function automatic longint unsigned mod_red(longint unsigned x, longint unsigned m);
    if (m < 2) return 0;
    return x % m;
  endfunction

  // both operands already reduced
  function automatic longint unsigned add_red(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
    longint unsigned s;
    s = x + y;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic longint unsigned mul_red(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
    return mod_red(mod_red(x, m) * mod_red(y, m), m);
  endfunction

  // fold one row into the column share, report the share on a last row
  function automatic void fold_row(input row_t r, output bit emits, output logic [VW-1:0] z);
    longint unsigned m;
    longint unsigned sum;
    m = modulus_reg;
    if (m < 2) begin
      sum = 0;
    end else begin
      sum = col_first ? mod_red(r.c, m) : mod_red(run_sum, m);
      sum = add_red(sum, mul_red(r.d, r.b, m), m);
      sum = add_red(sum, mul_red(r.a, r.e, m), m);
      if (party_zero_reg) sum = add_red(sum, mul_red(r.d, r.e, m), m);
    end
    emits = r.last;
    z = sum[VW-1:0];
    if (r.last) begin
      run_sum = '0;
      col_first = 1'b1;
    end else begin
      run_sum = sum[VW-1:0];
      col_first = 1'b0;
    end
  endfunction

  function automatic void plan_row(input logic [VW-1:0] d, input logic [VW-1:0] a,
                                   input logic [VW-1:0] b, input logic [VW-1:0] e,
                                   input logic [VW-1:0] c, input logic last,
                                   input bit typed = 1'b0, input logic [VW-1:0] z = '0);
    plan_t p;
    p.act = ACT_ROW;
    p.idx = CFG_MODULUS;
    p.val = '0;
    p.row = '{d: d, a: a, b: b, e: e, c: c, last: last};
    p.typed = typed;
    p.z = z;
    directed_plan.insert(directed_plan.size(), p);
  endfunction

  function automatic void plan_cfg(input cfg_idx_e idx, input logic [VW-1:0] val);
    plan_t p;
    p.act = ACT_CFG;
    p.idx = idx;
    p.val = val;
    p.row = '{d: '0, a: '0, b: '0, e: '0, c: '0, last: 1'b0};
    p.typed = 1'b0;
    p.z = '0;
    directed_plan.insert(directed_plan.size(), p);
  endfunction

  // operand values biased toward zero, all ones and the modulus boundary
  function automatic logic [VW-1:0] rand_field(input logic [VW-1:0] m);
    case ($urandom_range(7))
      0: return '0;
      1: return ONES;
      2: return m - 1'b1;
      3: return m;
      4: return m + 1'b1;
      5: return VW'($urandom_range(15));
      default: return VW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_modulus();
    case ($urandom_range(9))
      0: return VW'($urandom_range(1));
      1: return VW'(2);
      2: return ONES;
      3: return ONES - VW'($urandom_range(5));
      4: return VW'(1) << $urandom_range(VW - 1, 1);
      5, 6: return VW'($urandom_range(1000, 3));
      default: return VW'($urandom);
    endcase
  endfunction

  function automatic row_t rand_row(input logic last);
    row_t r;
    r.d = rand_field(modulus_reg);
    r.a = rand_field(modulus_reg);
    r.b = rand_field(modulus_reg);
    r.e = rand_field(modulus_reg);
    r.c = rand_field(modulus_reg);
    r.last = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                 input logic [VW-1:0] want);
    $display("%0t ns: share mismatch (%s): got %0d, wanted %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // offer one row, entered and left just after a falling edge
  task automatic send_row(input row_t r, input bit typed, input logic [VW-1:0] z_typed);
    bit            emits;
    logic [VW-1:0] z;
    while ($urandom_range(99) < sender_idle_pct) begin
      row_ch.valid = 1'b0;
      @(negedge clk);
    end
    row_ch.valid    = 1'b1;
    row_ch.d_value  = r.d;
    row_ch.a_share  = r.a;
    row_ch.b_share  = r.b;
    row_ch.e_value  = r.e;
    row_ch.c_share  = r.c;
    row_ch.last_row = r.last;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    fold_row(r, emits, z);
    if (emits) pending_shares.insert(pending_shares.size(), typed ? z_typed : z);
    rows_sent++;
    @(negedge clk);
  endtask

  // stop offering, wait for every share, then let rows without a share run out
  task automatic settle_block();
    row_ch.valid = 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [VW-1:0] val);
    settle_block();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MODULUS:    modulus_reg = val;
      CFG_PARTY_ZERO: party_zero_reg = val[0];
      default: ;
    endcase
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    share_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        share_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        share_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // compare each share transaction with the oldest expected share
  always @(posedge clk) begin
    if (rst_n && share_ch.valid && share_ch.ready) begin
      if (pending_shares.size() == 0) begin
        report_mismatch("none expected", share_ch.z_share, '0);
      end else begin
        if (share_ch.z_share !== pending_shares[0])
          report_mismatch("value", share_ch.z_share, pending_shares[0]);
        void'(pending_shares.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("beaver_vector_matrix_share_unit_test: errors");
      $finish;
    end
  end

  initial begin
    plan_t step;
    row_t  r;
    int    phase;
    int    phase_rows;
    int    col_len;
    int    target;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_MODULUS;
    cfg_data        = '0;
    row_ch.valid    = 1'b0;
    row_ch.d_value  = '0;
    row_ch.a_share  = '0;
    row_ch.b_share  = '0;
    row_ch.e_value  = '0;
    row_ch.c_share  = '0;
    row_ch.last_row = 1'b0;
    modulus_reg     = VW'(64);
    party_zero_reg  = 1'b0;
    run_sum         = '0;
    col_first       = 1'b1;

    // reset settings: modulus 64, no d*e term
    plan_row(1, 2, 3, 4, 5, 1'b1, 1'b1, 16);
    plan_row(0, 0, 0, 0, 0, 1'b1, 1'b1, 0);
    plan_row(ONES, ONES, ONES, ONES, ONES, 1'b1, 1'b1, 1);
    // three-row column, c on later rows must be ignored
    plan_row(7, 9, 11, 13, 60, 1'b0);
    plan_row(70, 80, 90, 100, ONES, 1'b0);
    plan_row(ONES, 3, ONES, 5, ONES, 1'b1);
    // party zero adds d*e
    plan_cfg(CFG_PARTY_ZERO, 1);
    plan_row(1, 2, 3, 4, 5, 1'b1, 1'b1, 20);
    plan_row(31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555, 31'h7000_0001, 31'h1234_5678, 1'b0);
    plan_row(31'h7FFF_FFFE, 1, 31'h3FFF_FFFF, 31'h6000_0000, ONES, 1'b1);
    // largest modulus: all ones reduce to zero, one below is minus one
    plan_cfg(CFG_MODULUS, ONES);
    plan_row(ONES, ONES, ONES, ONES, ONES, 1'b1, 1'b1, 0);
    plan_row(ONES - 1'b1, ONES - 1'b1, ONES - 1'b1, ONES - 1'b1, ONES - 1'b1, 1'b1, 1'b1, 2);
    // column left open across a modulus change
    plan_row(123456789, 987654321, 31'h7ABC_DEF0, 31'h0F0F_0F0F, 31'h7FFF_0000, 1'b0);
    plan_cfg(CFG_MODULUS, 1000);
    plan_row(1500, 2500, 3, 4, 999, 1'b1);
    // degenerate moduli give zero shares
    plan_cfg(CFG_MODULUS, 0);
    plan_row(5, 6, 7, 8, 9, 1'b0);
    plan_row(ONES, ONES, 1, 1, 1, 1'b1, 1'b1, 0);
    plan_cfg(CFG_MODULUS, 1);
    plan_row(3, 3, 3, 3, 3, 1'b1, 1'b1, 0);
    // smallest proper modulus
    plan_cfg(CFG_MODULUS, 2);
    plan_cfg(CFG_PARTY_ZERO, 0);
    plan_row(1, 1, 1, 1, 1, 1'b0);
    plan_row(ONES, 0, ONES, 1, 0, 1'b1);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed rows
    for (int i = 0; i < directed_plan.size(); i++) begin
      step = directed_plan[i];
      if (step.act == ACT_CFG) write_reg(step.idx, step.val);
      else send_row(step.row, step.typed, step.z);
    end

    // back-pressure: receiver holds off while rows keep coming
    write_reg(CFG_MODULUS, rand_modulus());
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    for (int i = 0; i < PRESSURE_ROWS; i++) begin
      r = rand_row(($urandom_range(3) != 0) || (i == PRESSURE_ROWS - 1));
      send_row(r, 1'b0, '0);
    end
    // sender pauses until every share is back
    settle_block();

    // random columns, new settings and idle pattern per phase
    target = rows_sent + RANDOM_ROWS;
    phase = 0;
    while (rows_sent < target) begin
      if (phase == 0 || $urandom_range(3) != 0) write_reg(CFG_MODULUS, rand_modulus());
      if ($urandom_range(1) == 0) write_reg(CFG_PARTY_ZERO, VW'($urandom_range(1)));
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      phase_rows = 0;
      while (phase_rows < ROWS_PER_PHASE) begin
        col_len = ($urandom_range(4) != 0) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        for (int k = 0; k < col_len; k++) begin
          send_row(rand_row(k == col_len - 1), 1'b0, '0);
          phase_rows++;
        end
      end
      // now and then leave a column open into the next settings
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(2, 1)) send_row(rand_row(1'b0), 1'b0, '0);
      end
      phase++;
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("beaver_vector_matrix_share_unit_test: clean");
    end else begin
      $display("beaver_vector_matrix_share_unit_test: errors");
    end
    $finish;
  end

endmodule
